// ----- rtl/crs_pkg.sv -----
// Shared constants, types and helper functions of the cubic interpolation resampler.
// Used by the channel interfaces, the lanes, the merge stage and the top level.
package crs_pkg;

   localparam int MAX_CHANNELS   = 8;
   localparam int HISTORY_POINTS = 4;
   localparam int FRAC_BITS      = 16;
   localparam int GUARD_BITS     = 8;
   localparam int SAMPLE_W       = 24;
   localparam int PHASE_W        = FRAC_BITS + 5;
   localparam int MAX_OUT        = 64;
   localparam int COUNT_W        = $clog2(MAX_OUT);
   localparam int CH_CNT_W       = 4;
   localparam int CSR_INDEX_W    = 4;
   localparam int CSR_DATA_W     = PHASE_W;

   // Cubic coefficients need three bits above a sample; Horner intermediates keep
   // the guard bits and four bits of headroom.
   localparam int COEF_W = SAMPLE_W + 3;
   localparam int H_W    = SAMPLE_W + GUARD_BITS + 4;
   localparam int SUM_W  = H_W + FRAC_BITS + 1;

   localparam logic [CSR_INDEX_W-1:0] REG_STEP          = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = CSR_INDEX_W'(1);

   localparam logic [PHASE_W-1:0]  STEP_RESET     = PHASE_W'(2 ** FRAC_BITS);
   localparam logic [CH_CNT_W-1:0] CH_COUNT_RESET = CH_CNT_W'(2);
   localparam logic [PHASE_W:0]    PHASE_ONE      = (PHASE_W + 1)'(2 ** FRAC_BITS);
   localparam logic [COUNT_W-1:0]  LAST_COUNT     = COUNT_W'(MAX_OUT - 1);

   localparam logic signed [H_W-1:0] SAT_HI = H_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [H_W-1:0] SAT_LO = -SAT_HI - H_W'(1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type frame_type [MAX_CHANNELS];

   typedef struct packed {
      logic                 shift;
      logic                 start;
      logic [FRAC_BITS-1:0] mu;
   } lane_ctrl_type;

   typedef struct packed {
      logic load;
      logic last;
   } merge_ctrl_type;

   // Half of one unit at the given shift, for round-half-up.
   function automatic logic signed [SUM_W-1:0] round_half(input int s);
      logic signed [SUM_W-1:0] r;
      r = '0;
      if (s > 0) begin
         r[s-1] = 1'b1;
      end
      return r;
   endfunction

   function automatic sample_type saturate(input logic signed [H_W-1:0] v);
      logic signed [H_W-1:0] c;
      c = v;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end
      return c[SAMPLE_W-1:0];
   endfunction

endpackage

// ----- rtl/crs_req_if.sv -----
// Input channel of the resampler: one audio frame per word.
// Depends on crs_pkg for the sample type.
interface crs_req_if;
   logic                 valid;
   logic                 ready;
   crs_pkg::sample_type  sample_ch0;
   crs_pkg::sample_type  sample_ch1;
   crs_pkg::sample_type  sample_ch2;
   crs_pkg::sample_type  sample_ch3;
   crs_pkg::sample_type  sample_ch4;
   crs_pkg::sample_type  sample_ch5;
   crs_pkg::sample_type  sample_ch6;
   crs_pkg::sample_type  sample_ch7;

   modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                   sample_ch4, sample_ch5, sample_ch6, sample_ch7, input ready);
   modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                 sample_ch4, sample_ch5, sample_ch6, sample_ch7, output ready);
endinterface

// ----- rtl/crs_rsp_if.sv -----
// Result channel of the resampler: one interpolated frame per word.
// Depends on crs_pkg for the sample type.
interface crs_rsp_if;
   logic                 valid;
   logic                 ready;
   crs_pkg::sample_type  out_ch0;
   crs_pkg::sample_type  out_ch1;
   crs_pkg::sample_type  out_ch2;
   crs_pkg::sample_type  out_ch3;
   crs_pkg::sample_type  out_ch4;
   crs_pkg::sample_type  out_ch5;
   crs_pkg::sample_type  out_ch6;
   crs_pkg::sample_type  out_ch7;
   logic                 last_in_run;

   modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
                   out_ch6, out_ch7, last_in_run, input ready);
   modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
                 out_ch6, out_ch7, last_in_run, output ready);
endinterface

// ----- rtl/crs_csr_if.sv -----
// Register write channel of the resampler: index and data per word.
// Depends on crs_pkg for the field widths.
interface crs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [crs_pkg::CSR_INDEX_W-1:0] index;
   logic [crs_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/crs_lane.sv -----
// One channel lane: four-point history and an iterative Horner evaluator that
// shares one multiplier over three steps. Depends on crs_pkg.
module crs_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  crs_pkg::lane_ctrl_type ctrl,
   input  crs_pkg::sample_type    sample_in,
   output crs_pkg::sample_type    result,
   output logic                   done
);

   typedef enum logic [1:0] {LS_IDLE, LS_H1, LS_H2, LS_Y} state_type;
   typedef logic signed [crs_pkg::COEF_W-1:0] coef_type;
   typedef logic signed [crs_pkg::SUM_W-1:0]  sum_type;

   state_type                      state_ff, state_in;
   logic                           done_ff, done_in;
   crs_pkg::sample_type            hist_ff [crs_pkg::HISTORY_POINTS];
   crs_pkg::sample_type            hist_in [crs_pkg::HISTORY_POINTS];
   coef_type                       coef_ff [4];
   coef_type                       coef_in [4];
   logic [crs_pkg::FRAC_BITS-1:0]  mu_ff, mu_in;
   logic signed [crs_pkg::H_W-1:0] acc_ff, acc_in;
   crs_pkg::sample_type            result_ff, result_in;

   coef_type                       y0, y1, y2, y3, a0;
   logic signed [crs_pkg::FRAC_BITS:0] mu_s;
   logic signed [crs_pkg::H_W-1:0] mul_a;
   sum_type                        prod, addend, half, total, shifted;

   always_comb begin
      y0 = crs_pkg::COEF_W'(hist_ff[0]);
      y1 = crs_pkg::COEF_W'(hist_ff[1]);
      y2 = crs_pkg::COEF_W'(hist_ff[2]);
      y3 = crs_pkg::COEF_W'(hist_ff[3]);
      a0 = y3 - y2 - y0 + y1;

      mu_s = {1'b0, mu_ff};
      mul_a = acc_ff;
      addend = crs_pkg::SUM_W'(coef_ff[3]) <<< (crs_pkg::FRAC_BITS + crs_pkg::GUARD_BITS);
      half = crs_pkg::round_half(crs_pkg::FRAC_BITS + crs_pkg::GUARD_BITS);
      case (state_ff)
         LS_H1: begin
            mul_a = crs_pkg::H_W'(coef_ff[0]);
            addend = crs_pkg::SUM_W'(coef_ff[1]) <<< crs_pkg::FRAC_BITS;
            half = crs_pkg::round_half(crs_pkg::FRAC_BITS - crs_pkg::GUARD_BITS);
         end
         LS_H2: begin
            addend = crs_pkg::SUM_W'(coef_ff[2]) <<< (crs_pkg::FRAC_BITS + crs_pkg::GUARD_BITS);
            half = crs_pkg::round_half(crs_pkg::FRAC_BITS);
         end
         default: ;
      endcase
      prod = crs_pkg::SUM_W'(mul_a) * crs_pkg::SUM_W'(mu_s);
      total = prod + addend + half;
      case (state_ff)
         LS_H1:   shifted = total >>> (crs_pkg::FRAC_BITS - crs_pkg::GUARD_BITS);
         LS_H2:   shifted = total >>> crs_pkg::FRAC_BITS;
         default: shifted = total >>> (crs_pkg::FRAC_BITS + crs_pkg::GUARD_BITS);
      endcase
   end

   always_comb begin
      hist_in = hist_ff;
      if (ctrl.shift) begin
         for (int k = 0; k < crs_pkg::HISTORY_POINTS - 1; k++) begin
            hist_in[k] = hist_ff[k+1];
         end
         hist_in[crs_pkg::HISTORY_POINTS-1] = sample_in;
      end

      state_in = state_ff;
      done_in = 1'b0;
      coef_in = coef_ff;
      mu_in = mu_ff;
      acc_in = acc_ff;
      result_in = result_ff;
      case (state_ff)
         LS_IDLE: begin
            if (ctrl.start) begin
               coef_in[0] = a0;
               coef_in[1] = y0 - y1 - a0;
               coef_in[2] = y2 - y0;
               coef_in[3] = y1;
               mu_in = ctrl.mu;
               state_in = LS_H1;
            end
         end
         LS_H1: begin
            acc_in = shifted[crs_pkg::H_W-1:0];
            state_in = LS_H2;
         end
         LS_H2: begin
            acc_in = shifted[crs_pkg::H_W-1:0];
            state_in = LS_Y;
         end
         LS_Y: begin
            result_in = crs_pkg::saturate(shifted[crs_pkg::H_W-1:0]);
            done_in = 1'b1;
            state_in = LS_IDLE;
         end
         default: state_in = LS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_IDLE;
         done_ff <= 1'b0;
         hist_ff <= '{default: '0};
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         hist_ff <= hist_in;
      end
      coef_ff <= coef_in;
      mu_ff <= mu_in;
      acc_ff <= acc_in;
      result_ff <= result_in;
   end

   assign result = result_ff;
   assign done = done_ff;

endmodule

// ----- rtl/crs_merge.sv -----
// Merge stage: gathers the lane results into one output frame, blanks unused
// channels and holds the frame in the result register. Depends on crs_pkg, crs_rsp_if.
module crs_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  crs_pkg::merge_ctrl_type         ctrl,
   input  logic [crs_pkg::CH_CNT_W-1:0]    channel_count,
   input  crs_pkg::frame_type              lane_result,
   output logic                            free,
   crs_rsp_if.source                       rsp_ch
);

   logic                valid_ff, valid_in;
   logic                last_ff, last_in;
   crs_pkg::frame_type  out_ff, out_in;

   always_comb begin
      free = !valid_ff || rsp_ch.ready;
      valid_in = valid_ff && !rsp_ch.ready;
      last_in = last_ff;
      out_in = out_ff;
      if (ctrl.load) begin
         valid_in = 1'b1;
         last_in = ctrl.last;
         // A count above the lane count simply enables every lane.
         for (int ch = 0; ch < crs_pkg::MAX_CHANNELS; ch++) begin
            if (crs_pkg::CH_CNT_W'(ch) < channel_count) begin
               out_in[ch] = lane_result[ch];
            end else begin
               out_in[ch] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      last_ff <= last_in;
      out_ff <= out_in;
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.last_in_run = last_ff;
   assign rsp_ch.out_ch0 = out_ff[0];
   assign rsp_ch.out_ch1 = out_ff[1];
   assign rsp_ch.out_ch2 = out_ff[2];
   assign rsp_ch.out_ch3 = out_ff[3];
   assign rsp_ch.out_ch4 = out_ff[4];
   assign rsp_ch.out_ch5 = out_ff[5];
   assign rsp_ch.out_ch6 = out_ff[6];
   assign rsp_ch.out_ch7 = out_ff[7];

endmodule

// ----- rtl/cubic_interp_resampler_top.sv -----
// Cubic interpolation resampler. A frame word with no output only shifts the history and lowers the phase.
// Each output frame goes through lane start, three Horner steps through the
// one multiplier per lane, and the hand-off to the result register, which waits
// while the result register still holds a word that has not been taken.
// Up to 64 outputs per frame.
// Synchronous reset clears history and phase and empties the result register; step=1.0, two channels.
module cubic_interp_resampler_top (
   input  logic    clock,
   input  logic    reset,
   crs_req_if.sink   req_ch,
   crs_rsp_if.source rsp_ch,
   crs_csr_if.sink   csr_ch
);

   typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_OUT} state_type;

   state_type                      state_ff, state_in;
   logic [crs_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic [crs_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [crs_pkg::PHASE_W-1:0]    step_ff, step_in;
   logic [crs_pkg::CH_CNT_W-1:0]   chan_count_ff, chan_count_in;

   logic                           req_accept;
   logic                           csr_write;
   logic [crs_pkg::PHASE_W:0]      phase_wide, next_phase;
   logic                           run_end;
   logic                           merge_free;
   logic [crs_pkg::MAX_CHANNELS-1:0] lane_done;
   crs_pkg::lane_ctrl_type         lane_ctrl;
   crs_pkg::merge_ctrl_type        merge_ctrl;
   crs_pkg::frame_type             req_frame, lane_result;

   assign req_frame[0] = req_ch.sample_ch0;
   assign req_frame[1] = req_ch.sample_ch1;
   assign req_frame[2] = req_ch.sample_ch2;
   assign req_frame[3] = req_ch.sample_ch3;
   assign req_frame[4] = req_ch.sample_ch4;
   assign req_frame[5] = req_ch.sample_ch5;
   assign req_frame[6] = req_ch.sample_ch6;
   assign req_frame[7] = req_ch.sample_ch7;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_write = csr_ch.valid && csr_ch.ready;

   always_comb begin
      step_in = step_ff;
      chan_count_in = chan_count_ff;
      if (csr_write) begin
         case (csr_ch.index)
            crs_pkg::REG_STEP:          step_in = csr_ch.data;
            crs_pkg::REG_CHANNEL_COUNT: chan_count_in = csr_ch.data[crs_pkg::CH_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      merge_ctrl = '0;
      phase_wide = {1'b0, phase_ff};
      next_phase = phase_wide + {1'b0, step_ff};
      // The run ends when the phase reaches one or the output cap is hit.
      run_end = (next_phase >= crs_pkg::PHASE_ONE) || (count_ff == crs_pkg::LAST_COUNT);
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (phase_wide >= crs_pkg::PHASE_ONE) begin
                  phase_in = crs_pkg::PHASE_W'(phase_wide - crs_pkg::PHASE_ONE);
               end else begin
                  count_in = '0;
                  state_in = ST_START;
               end
            end
         end
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (&lane_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (merge_free) begin
               merge_ctrl.load = 1'b1;
               merge_ctrl.last = run_end;
               if (run_end) begin
                  // A run cut short by the cap leaves the phase below one: it restarts at zero.
                  if (next_phase >= crs_pkg::PHASE_ONE) begin
                     phase_in = crs_pkg::PHASE_W'(next_phase - crs_pkg::PHASE_ONE);
                  end else begin
                     phase_in = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  phase_in = next_phase[crs_pkg::PHASE_W-1:0];
                  count_in = count_ff + crs_pkg::COUNT_W'(1);
                  state_in = ST_START;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         count_ff <= '0;
         step_ff <= crs_pkg::STEP_RESET;
         chan_count_ff <= crs_pkg::CH_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         step_ff <= step_in;
         chan_count_ff <= chan_count_in;
      end
   end

   assign lane_ctrl.shift = req_accept;
   assign lane_ctrl.start = (state_ff == ST_START);
   assign lane_ctrl.mu = phase_ff[crs_pkg::FRAC_BITS-1:0];

   for (genvar ch = 0; ch < crs_pkg::MAX_CHANNELS; ch++) begin : g_lane
      crs_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .sample_in (req_frame[ch]),
         .result    (lane_result[ch]),
         .done      (lane_done[ch])
      );
   end

   crs_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (merge_ctrl),
      .channel_count (chan_count_ff),
      .lane_result   (lane_result),
      .free          (merge_free),
      .rsp_ch        (rsp_ch)
   );

endmodule

// ----- rtl/crs_checker.sv -----
// Port-level checker for the resampler top level, attached by the bind below.
// Depends only on the top-level ports.
module crs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);

   // A waiting result word stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // While a word that is not the last of its run is offered, the run is still going.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("frame input open in the middle of a run");

   // A new result word never appears in the cycle right after a frame is taken.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result word appeared too early");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid after reset");

endmodule

bind cubic_interp_resampler_top crs_checker u_crs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_last  (rsp_ch.last_in_run)
);
